### rtl/sil_pkg.sv
`timescale 1ns / 1ps

package sil_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int DIST_W   = 17;
	localparam int OBJ_W    = 16;

	localparam logic [DIST_W-1:0] ONE_FIX = 17'h10000;
	localparam logic [CNT_W-1:0]  CAP_CNT = CNT_W'(CAPACITY);

	// operation codes
	localparam logic [1:0] F_CLEAR    = 2'd0;
	localparam logic [1:0] F_INSERT   = 2'd1;
	localparam logic [1:0] F_TRAVERSE = 2'd2;

	// status codes
	localparam logic [2:0] ST_DONE  = 3'd0;
	localparam logic [2:0] ST_RANGE = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_NULL  = 3'd3;
	localparam logic [2:0] ST_ENTRY = 3'd4;
	localparam logic [2:0] ST_EMPTY = 3'd5;

	typedef struct packed {
		logic              kind;
		logic [OBJ_W-1:0]  obj;
		logic [DIST_W-1:0] distance;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
		logic [IDX_W-1:0] rd_addr;
	} ram_cmd_t;

	typedef struct packed {
		logic              ld;
		logic [2:0]        status;
		logic              kind;
		logic [OBJ_W-1:0]  obj;
		logic [DIST_W-1:0] distance;
		logic              last;
	} res_ld_t;

endpackage

### rtl/sil_if.sv
`timescale 1ns / 1ps

interface sil_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic               kind;
	logic signed [17:0] distance;
	logic [15:0]        object_id;

	modport source (output valid, func, kind, distance, object_id, input ready);
	modport sink   (input valid, func, kind, distance, object_id, output ready);
endinterface

interface sil_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        out_kind;
	logic [15:0] out_object;
	logic [16:0] out_distance;
	logic        last;

	modport source (output valid, status, out_kind, out_object, out_distance, last,
		input ready);
	modport sink   (input valid, status, out_kind, out_object, out_distance, last,
		output ready);
endinterface

### rtl/sil_ram.sv
`timescale 1ns / 1ps

module sil_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### rtl/sil_obuf.sv
`timescale 1ns / 1ps

// Result register: holds one beat until the sink takes it.
module sil_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  sil_pkg::res_ld_t ld,
	output logic             free,
	sil_rsp_if.source        rsp
);

	logic             valid_q;
	sil_pkg::res_ld_t data_q;

	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= ld.ld;
		end
	end

	always_ff @(posedge clk) begin
		if (free && ld.ld) begin
			data_q <= ld;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.status       = data_q.status;
	assign rsp.out_kind     = data_q.kind;
	assign rsp.out_object   = data_q.obj;
	assign rsp.out_distance = data_q.distance;
	assign rsp.last         = data_q.last;

	ast_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !rsp.ready |=> valid_q && $stable(data_q))
		else $error("result beat dropped while stalled");

	ast_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		ld.ld |-> free)
		else $error("result loaded into a busy register");

endmodule

### rtl/sil_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: one distance comparator, one RAM read and one RAM write per cycle.
module sil_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	sil_req_if.sink                      req,
	input  sil_pkg::entry_t              rd_data,
	input  logic                         out_free,
	output sil_pkg::ram_cmd_t            ram,
	output sil_pkg::res_ld_t             res
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RESP = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_HEAD = 3'd3;
	localparam logic [2:0] S_TRAV = 3'd4;

	logic [2:0]                 state_q, state_d;
	logic [sil_pkg::CNT_W-1:0]  count_q, count_d;
	logic [sil_pkg::IDX_W-1:0]  idx_q, idx_d;
	logic [2:0]                 status_q, status_d;
	sil_pkg::entry_t            new_q;
	logic                       accept;
	logic                       bigger;
	logic                       trav_last;
	logic [sil_pkg::IDX_W-1:0]  last_idx;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign last_idx  = sil_pkg::IDX_W'(count_q - 1'b1);
	// distance comparator: stored entry lies strictly beyond the new one
	assign bigger    = rd_data.distance > new_q.distance;
	assign trav_last = (idx_q == last_idx);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		status_d = status_q;
		ram      = '0;
		res      = '0;
		ram.rd_addr = idx_q;
		case (state_q)
			S_IDLE: begin
				ram.rd_addr = (req.func == sil_pkg::F_TRAVERSE) ? '0 : last_idx;
				if (accept) begin
					case (req.func)
						sil_pkg::F_CLEAR: begin
							count_d  = '0;
							status_d = sil_pkg::ST_DONE;
							state_d  = S_RESP;
						end
						sil_pkg::F_INSERT: begin
							state_d = S_RESP;
							if (req.object_id == '0) begin
								status_d = sil_pkg::ST_NULL;
							end else if (req.distance[17] ||
									req.distance[16:0] > sil_pkg::ONE_FIX) begin
								status_d = sil_pkg::ST_RANGE;
							end else if (count_q == sil_pkg::CAP_CNT) begin
								status_d = sil_pkg::ST_FULL;
							end else if (count_q == '0) begin
								state_d = S_HEAD;
							end else begin
								idx_d   = last_idx;
								state_d = S_SCAN;
							end
						end
						sil_pkg::F_TRAVERSE: begin
							if (count_q == '0) begin
								status_d = sil_pkg::ST_EMPTY;
								state_d  = S_RESP;
							end else begin
								idx_d   = '0;
								state_d = S_TRAV;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SCAN: begin
				ram.we = 1'b1;
				ram.wr_addr = idx_q + 1'b1;
				if (bigger) begin
					ram.wr_data = rd_data;
					if (idx_q == '0) begin
						state_d = S_HEAD;
					end else begin
						idx_d       = idx_q - 1'b1;
						ram.rd_addr = idx_q - 1'b1;
					end
				end else begin
					ram.wr_data = new_q;
					count_d     = count_q + 1'b1;
					status_d    = sil_pkg::ST_DONE;
					state_d     = S_RESP;
				end
			end
			S_HEAD: begin
				ram.we      = 1'b1;
				ram.wr_addr = '0;
				ram.wr_data = new_q;
				count_d     = count_q + 1'b1;
				status_d    = sil_pkg::ST_DONE;
				state_d     = S_RESP;
			end
			S_TRAV: begin
				if (out_free) begin
					res.ld       = 1'b1;
					res.status   = sil_pkg::ST_ENTRY;
					res.kind     = rd_data.kind;
					res.obj      = rd_data.obj;
					res.distance = rd_data.distance;
					res.last     = trav_last;
					if (trav_last) begin
						state_d = S_IDLE;
					end else begin
						idx_d       = idx_q + 1'b1;
						ram.rd_addr = idx_q + 1'b1;
					end
				end
			end
			S_RESP: begin
				if (out_free) begin
					res.ld     = 1'b1;
					res.status = status_q;
					res.last   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		status_q <= status_d;
		if (accept) begin
			new_q.kind     <= req.kind;
			new_q.obj      <= req.object_id;
			new_q.distance <= req.distance[16:0];
		end
	end

	ast_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sil_pkg::CAP_CNT)
		else $error("entry count beyond capacity");

	ast_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> sil_pkg::CNT_W'(idx_q) < count_q - 1'b1 ||
			sil_pkg::CNT_W'(idx_q) == count_q - 1'b1)
		else $error("insert scan outside the filled part");

	ast_trav_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TRAV |-> sil_pkg::CNT_W'(idx_q) < count_q)
		else $error("traversal outside the filled part");

	ast_grow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) && count_q != '0 |-> count_q == $past(count_q) + 1'b1)
		else $error("entry count moved by more than one");

endmodule

### rtl/sorted_intercept_list.sv
`timescale 1ns / 1ps

// channel  modport  beat contents
// -------  -------  ------------------------------------------------
// req      sink     func, kind, distance, object_id
// rsp      source   status, out_kind, out_object, out_distance, last
//
// Clear, and an insert that is refused, pass through S_RESP to the result beat.
// A good insert scans down from the tail, moving each larger entry up one
// place as it goes, then writes the new entry into the freed place.
// Traverse reads from the head: one beat a cycle while the output is free.
// req.ready is high only between operations; rsp stalls hold S_RESP, S_TRAV.
// Reset empties the list (count to zero); the entry RAM itself is not cleared.

module sorted_intercept_list (
	input  logic      clk,
	input  logic      arst_n,
	sil_req_if.sink   req,
	sil_rsp_if.source rsp
);

	sil_pkg::ram_cmd_t ram;
	sil_pkg::entry_t   rd_data;
	sil_pkg::res_ld_t  res;
	logic              out_free;

	// entry store: one write and one registered read per cycle
	sil_ram #(
		.WIDTH (sil_pkg::ENTRY_W),
		.DEPTH (sil_pkg::CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (ram.we),
		.wr_addr (ram.wr_addr),
		.wr_data (ram.wr_data),
		.rd_addr (ram.rd_addr),
		.rd_data (rd_data)
	);

	// sequencer with the single distance comparator
	sil_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rd_data  (rd_data),
		.out_free (out_free),
		.ram      (ram),
		.res      (res)
	);

	// result register towards the sink
	sil_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (res),
		.free   (out_free),
		.rsp    (rsp)
	);

endmodule

### tb/intercept_order_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the ordered list and checks
// every result beat against the oldest outstanding prediction.
module intercept_order_checker (
	input  logic        clk,
	input  logic        arst_n,
	sil_req_if          req,
	sil_rsp_if          rsp,
	output int unsigned fail_count,
	output int unsigned awaited,
	output int unsigned beats_checked,
	output int unsigned full_refusals
);
	import sil_pkg::*;

	localparam int MAX_REPORTS = 30;

	typedef struct packed {
		logic [2:0]        status;
		logic              kind;
		logic [OBJ_W-1:0]  obj;
		logic [DIST_W-1:0] distance;
		logic              last;
	} result_beat_t;

	entry_t       shadow_list [CAPACITY];
	int unsigned  shadow_len = 0;
	result_beat_t beats_due [$];
	result_beat_t seen;
	result_beat_t want;
	int unsigned  mismatches = 0;
	int unsigned  n_checked  = 0;
	int unsigned  n_full     = 0;

	// works out the result beats of one accepted request and updates the list
	task automatic predict_list_op(input logic [1:0] f, input logic k,
		input logic signed [17:0] d, input logic [OBJ_W-1:0] o);
		result_beat_t b;
		int unsigned  pos;
		int unsigned  i;
		b      = '0;
		b.last = 1'b1;
		case (f)
			F_CLEAR: begin
				shadow_len = 0;
				b.status   = ST_DONE;
				beats_due.push_back(b);
			end
			F_INSERT: begin
				// null handle wins over a bad distance
				if (o == '0)
					b.status = ST_NULL;
				else if (d < 0 || d > 18'sh10000)
					b.status = ST_RANGE;
				else if (shadow_len >= CAPACITY) begin
					b.status = ST_FULL;
					n_full++;
				end else begin
					// after every entry of equal or smaller distance
					pos = 0;
					while (pos < shadow_len &&
							shadow_list[pos].distance <= d[DIST_W-1:0])
						pos++;
					for (i = shadow_len; i > pos; i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[pos].kind     = k;
					shadow_list[pos].obj      = o;
					shadow_list[pos].distance = d[DIST_W-1:0];
					shadow_len++;
					b.status = ST_DONE;
				end
				beats_due.push_back(b);
			end
			F_TRAVERSE: begin
				if (shadow_len == 0) begin
					b.status = ST_EMPTY;
					beats_due.push_back(b);
				end else begin
					for (i = 0; i < shadow_len; i++) begin
						b.status   = ST_ENTRY;
						b.kind     = shadow_list[i].kind;
						b.obj      = shadow_list[i].obj;
						b.distance = shadow_list[i].distance;
						b.last     = (i + 1 == shadow_len);
						beats_due.push_back(b);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input int unsigned exp_v,
		input int unsigned got_v);
		if (exp_v != got_v) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_len = 0;
			beats_due.delete();
		end else begin
			if (req.valid && req.ready)
				predict_list_op(req.func, req.kind, req.distance, req.object_id);
			if (rsp.valid && rsp.ready) begin
				seen.status   = rsp.status;
				seen.kind     = rsp.out_kind;
				seen.obj      = rsp.out_object;
				seen.distance = rsp.out_distance;
				seen.last     = rsp.last;
				if (beats_due.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: no beat expected, got status %0d object %0d",
							$time, seen.status, seen.obj);
					mismatches++;
				end else begin
					want = beats_due.pop_front();
					check_field("status", want.status, seen.status);
					check_field("out_kind", want.kind, seen.kind);
					check_field("out_object", want.obj, seen.obj);
					check_field("out_distance", want.distance, seen.distance);
					check_field("last", want.last, seen.last);
					n_checked++;
				end
			end
		end
		fail_count    <= mismatches;
		awaited       <= beats_due.size();
		beats_checked <= n_checked;
		full_refusals <= n_full;
	end

endmodule

### tb/tb_sorted_intercept_list.sv
`timescale 1ns / 1ps

// Top of the bench: clock, reset, request stimulus, response back-pressure,
// watchdog and verdict. All prediction and checking is done in the checker.
module tb_sorted_intercept_list;
	import sil_pkg::*;

	localparam logic [1:0] F_UNUSED   = 2'd3; // spare op code, block ignores it
	localparam int         ITEM_GOAL  = 310;
	localparam int         RSP_HOLD   = 400;  // long receiver hold-off, cycles
	localparam int         DRAIN_TAIL = CAPACITY + 16;
	localparam int         QUIET_MAX  = 2000; // watchdog: cycles with no beat

	typedef enum int {RX_FLOW, RX_COIN, RX_COMB, RX_SPARSE} rx_mode_e;

	logic clk;
	logic arst_n;
	logic hold_ask;

	int unsigned fail_count;
	int unsigned awaited;
	int unsigned beats_checked;
	int unsigned full_refusals;

	int unsigned burst_left  = 0;
	int unsigned n_clear     = 0;
	int unsigned n_insert    = 0;
	int unsigned n_trav      = 0;
	int unsigned n_ignored   = 0;
	int unsigned quiet_count = 0;

	sil_req_if req_ch ();
	sil_rsp_if rsp_ch ();

	sorted_intercept_list u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	intercept_order_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.fail_count    (fail_count),
		.awaited       (awaited),
		.beats_checked (beats_checked),
		.full_refusals (full_refusals)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// distance pickers
	// ---------------------------------------------------------------

	// in range: both ends, a coarse grid to force ties, or anything in [0, 1.0]
	function automatic logic signed [17:0] good_distance();
		case ($urandom_range(0, 5))
			0:       return 18'sd0;
			1:       return 18'sh10000;
			2, 3:    return 18'($urandom_range(0, 8) * 8192);
			default: return 18'($urandom_range(0, 65536));
		endcase
	endfunction

	// negative, or above 1.0
	function automatic logic signed [17:0] bad_distance();
		int v;
		if ($urandom_range(0, 1))
			v = -int'($urandom_range(1, 131072));
		else
			v = int'($urandom_range(65537, 131071));
		return 18'(v);
	endfunction

	// ---------------------------------------------------------------
	// request driver: bursts of random length with random gaps between.
	// valid stays up across back-to-back beats, so it is only ever
	// assigned once per time step.
	// ---------------------------------------------------------------
	task automatic send_beat(input logic [1:0] f, input logic k,
		input logic signed [17:0] d, input logic [15:0] o);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// now and then a long burst with no idling at all
			burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
		end
		req_ch.valid     <= 1'b1;
		req_ch.func      <= f;
		req_ch.kind      <= k;
		req_ch.distance  <= d;
		req_ch.object_id <= o;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		burst_left--;
		case (f)
			F_CLEAR:    n_clear++;
			F_INSERT:   n_insert++;
			F_TRAVERSE: n_trav++;
			default:    n_ignored++;
		endcase
	endtask

	// stop offering and wait until the checker holds nothing outstanding;
	// a clock edge first so that the last accepted beat is counted
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// response side: stall pattern of its own, plus one long hold-off
	// when the stimulus asks for it
	// ---------------------------------------------------------------
	initial begin
		rx_mode_e    rx_mode;
		int unsigned mode_left;
		int unsigned phase;
		logic        hold_used;
		rsp_ch.ready <= 1'b0;
		rx_mode   = RX_FLOW;
		mode_left = 0;
		phase     = 0;
		hold_used = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_ask && !hold_used) begin
				// block backs up, sender keeps offering into a stalled input
				hold_used = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (RSP_HOLD) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				phase++;
				case (rx_mode)
					RX_FLOW:   rsp_ch.ready <= 1'b1;
					RX_COIN:   rsp_ch.ready <= 1'($urandom);
					RX_COMB:   rsp_ch.ready <= (phase % 4 != 0);
					default:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog: any accepted beat on either side counts as progress
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_count <= 0;
		else if (arst_n)
			quiet_count <= quiet_count + 1;
		if (quiet_count == QUIET_MAX) begin
			$display("%0t: no beat moved for %0d cycles", $time, QUIET_MAX);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	initial begin
		int unsigned roll;
		int unsigned i;
		arst_n           <= 1'b0;
		hold_ask         <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.func      <= F_CLEAR;
		req_ch.kind      <= 1'b0;
		req_ch.distance  <= '0;
		req_ch.object_id <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty traverse, refusals and their precedence,
		// both ends of the range, ties, the spare op code, clear
		send_beat(F_TRAVERSE, 1'b0, 18'sd0, 16'd0);
		send_beat(F_INSERT, 1'b1, -18'sd5, 16'd0);       // null beats bad range
		send_beat(F_INSERT, 1'b0, 18'sd100, 16'd0);      // null handle
		send_beat(F_INSERT, 1'b0, -18'sd1, 16'd1);       // just below 0.0
		send_beat(F_INSERT, 1'b1, -18'sd131072, 16'd2);  // most negative
		send_beat(F_INSERT, 1'b0, 18'sd65537, 16'd3);    // just above 1.0
		send_beat(F_INSERT, 1'b1, 18'sd131071, 16'd4);   // largest positive
		send_beat(F_INSERT, 1'b1, 18'sh10000, 16'hFFFF); // exactly 1.0
		send_beat(F_INSERT, 1'b0, 18'sd0, 16'd10);       // exactly 0.0
		send_beat(F_INSERT, 1'b1, 18'sd30000, 16'd11);
		send_beat(F_INSERT, 1'b0, 18'sd30000, 16'd12);   // tie, goes behind
		send_beat(F_INSERT, 1'b1, 18'sd0, 16'd13);       // tie at 0.0
		send_beat(F_UNUSED, 1'b1, 18'h2AAAA, 16'h5555);  // ignored, no beat
		send_beat(F_TRAVERSE, 1'b1, 18'h15555, 16'hAAAA);
		send_beat(F_CLEAR, 1'b1, 18'h3FFFF, 16'hFFFF);
		send_beat(F_TRAVERSE, 1'b0, 18'sd0, 16'd0);
		send_beat(F_INSERT, 1'b1, 18'sd1, 16'h8001);
		send_beat(F_TRAVERSE, 1'b0, 18'sd0, 16'd0);
		send_beat(F_CLEAR, 1'b0, 18'sd0, 16'd0);

		// fill to capacity and past it while the receiver holds off, so the
		// block backs up; then a full-length traversal
		hold_ask <= 1'b1;
		send_beat(F_CLEAR, 1'b0, 18'sd0, 16'd0);
		for (i = 0; i < CAPACITY + 2; i++)
			send_beat(F_INSERT, 1'($urandom), good_distance(), 16'($urandom_range(1, 65535)));
		send_beat(F_TRAVERSE, 1'($urandom), 18'($urandom), 16'($urandom));

		// sender pauses here until every result has come back
		drain_results();

		// random episodes: mostly a clear followed by well-formed inserts with
		// traversals in between, with a sprinkling of refusals and noise
		while (n_clear + n_insert + n_trav < ITEM_GOAL) begin
			if ($urandom_range(0, 9) < 7)
				send_beat(F_CLEAR, 1'($urandom), 18'($urandom), 16'($urandom));
			repeat ($urandom_range(1, 14)) begin
				roll = $urandom_range(0, 99);
				if (roll < 72)
					send_beat(F_INSERT, 1'($urandom), good_distance(),
						16'($urandom_range(1, 65535)));
				else if (roll < 86)
					send_beat(F_TRAVERSE, 1'($urandom), 18'($urandom), 16'($urandom));
				else if (roll < 90)
					send_beat(F_INSERT, 1'($urandom), good_distance(), 16'd0);
				else if (roll < 95)
					send_beat(F_INSERT, 1'($urandom), bad_distance(),
						16'($urandom_range(1, 65535)));
				else if (roll < 97)
					send_beat(F_UNUSED, 1'($urandom), 18'($urandom), 16'($urandom));
				else
					send_beat(F_CLEAR, 1'($urandom), 18'($urandom), 16'($urandom));
			end
		end

		// wind down: everything back, then enough cycles for a stray beat
		drain_results();
		repeat (DRAIN_TAIL) @(posedge clk);

		$display("Covered %0d requests: %0d clears, %0d inserts, %0d traversals, %0d spare codes.",
			n_clear + n_insert + n_trav + n_ignored, n_clear, n_insert, n_trav, n_ignored);
		$display("Checked %0d result beats, %0d inserts refused on a full list.",
			beats_checked, full_refusals);
		if (fail_count == 0 && awaited == 0) begin
			$display("RESULT: OK");
		end else begin
			if (awaited != 0)
				$display("%0t: %0d result beats never arrived", $time, awaited);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
